@@ rtl/gifd_pkg.sv @@
// Shared constants, types and field-size lookup for the GNSS/IMU frame deframer.
// No dependencies; used by the field interface, the core and the checker.
package gifd_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;
    localparam logic [7:0] STATUS_MASK = 8'h3F;

    localparam int STORE_FIRST = 3;
    localparam int STORE_DEPTH = 65;
    localparam int IDX_WIDTH   = $clog2(STORE_DEPTH);
    localparam int FIELD_COUNT = 20;
    localparam int ID_WIDTH    = 5;
    localparam int VALUE_WIDTH = 64;
    localparam int QUAL_WIDTH  = 2;

    typedef logic [ID_WIDTH-1:0]    field_id_t;
    typedef logic [IDX_WIDTH-1:0]   store_idx_t;
    typedef logic [VALUE_WIDTH-1:0] field_value_t;
    typedef logic [QUAL_WIDTH-1:0]  quality_t;

    // Field identifiers
    localparam field_id_t ID_MODE     = 5'd0;
    localparam field_id_t ID_WEEK     = 5'd1;
    localparam field_id_t ID_MS       = 5'd2;
    localparam field_id_t ID_SATS     = 5'd3;
    localparam field_id_t ID_LAT      = 5'd4;
    localparam field_id_t ID_LON      = 5'd5;
    localparam field_id_t ID_ALT      = 5'd6;
    localparam field_id_t ID_HEADING  = 5'd12;
    localparam field_id_t ID_ACCEL_X  = 5'd13;
    localparam field_id_t ID_RATE_Z   = 5'd18;
    localparam field_id_t ID_STATUS   = 5'd19;

    // Quality codes for the status field
    localparam quality_t QUAL_BAD        = 2'd0;
    localparam quality_t QUAL_CONVERGING = 2'd1;
    localparam quality_t QUAL_GOOD       = 2'd2;

    // Number of bytes in a field, minus one
    function automatic logic [2:0] field_len(input field_id_t id);
        logic [2:0] r;
        case (id) inside
            ID_MODE, ID_SATS, ID_STATUS:    r = 3'd0;
            ID_WEEK, [ID_ACCEL_X:ID_RATE_Z]: r = 3'd1;
            ID_MS, [ID_ALT:ID_HEADING]:     r = 3'd3;
            default:                        r = 3'd7;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/gifd_byte_if.sv @@
// Byte channel: valid/ready handshake carrying one received serial byte.
// Depends on nothing.
interface gifd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

@@ rtl/gifd_field_if.sv @@
// Field channel: valid/ready handshake carrying one decoded frame field.
// Depends on gifd_pkg for the payload types.
interface gifd_field_if;
    logic                  valid;
    logic                  ready;
    gifd_pkg::field_id_t    field_id;
    gifd_pkg::field_value_t field_value;
    gifd_pkg::quality_t     quality;
    logic                  last_field;

    modport source (output valid, output field_id, output field_value, output quality,
                    output last_field, input ready);
    modport sink   (input valid, input field_id, input field_value, input quality,
                    input last_field, output ready);
endinterface

@@ rtl/gnss_imu_frame_deframer_core.sv @@
// Top level of the GNSS/IMU frame deframer: sync hunt, byte store and field emitter.
// Depends on gifd_pkg, gifd_byte_if and gifd_field_if.
//
// Usage
//   byte_in   : one serial byte per request. The block hunts for AA then 55, takes a
//               length byte L and then L+1 body bytes. Body bytes at frame offsets
//               3..67 go into a 65-byte single-port-write store with a registered read.
//   field_out : at frame end the block emits 20 little-endian fields, id 0..19, the
//               last one marked with last_field. Short frames reuse stale store bytes.
//   Emitter   : after the closing byte is taken the emitter reads the store one byte a
//               cycle while the read data stage is not held, so a full run of 20
//               fields reads all 65 store bytes through the issue and data stages.
//   Throughput: one byte per cycle unless the store interlock holds it. While a run is
//               being emitted, body bytes of the next frame are taken as long as their
//               store entry has already been read; a closing byte waits until every
//               store read of the run is issued. The store read port therefore sets
//               the frame rate: one full run of store reads per frame.
//   Reset     : rst_n clears the hunt, the emitter and the per-entry valid bits, so
//               the store reads as all zero until written.
//   Stall     : when field_out is stalled the output register holds its request, the
//               emitter stops reads once a field's last byte waits in the data stage,
//               and back-pressure reaches byte_in only via the store interlock above.
module gnss_imu_frame_deframer_core (
    input  logic               clk,
    input  logic               rst_n,
    gifd_byte_if.sink          byte_in,
    gifd_field_if.source       field_out
);

    localparam int POS_WIDTH   = 9;
    localparam int LAST_IDX    = gifd_pkg::STORE_DEPTH - 1;
    localparam int IDX_WIDTH_C = gifd_pkg::IDX_WIDTH;

    // Frame tracking
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [7:0]           len_reg, len_next;

    logic [POS_WIDTH-1:0] frame_end;
    logic [POS_WIDTH-1:0] wr_off;
    logic                 in_body;
    logic                 at_end;
    logic                 past_end;
    logic                 in_store;
    logic                 blocked;
    logic                 accept;
    logic                 wr_en;
    logic                 emit_start;

    // Byte store and its valid bits
    logic [7:0]                        mem [gifd_pkg::STORE_DEPTH];
    logic [gifd_pkg::STORE_DEPTH-1:0]  vld_reg;

    // Read issue stage
    logic                  busy_reg;
    gifd_pkg::store_idx_t  rd_idx_reg;
    gifd_pkg::field_id_t   f_id_reg;
    logic [2:0]            f_bpos_reg;
    logic                  f_lastb;
    logic                  rd_en;

    // Read data stage
    logic                  d_vld_reg;
    gifd_pkg::field_id_t   d_id_reg;
    logic [2:0]            d_bpos_reg;
    logic                  d_last_reg;
    logic                  d_bv_reg;
    logic [7:0]            rd_data_reg;
    logic                  d_take;
    logic [7:0]            d_byte;

    // Field assembly
    gifd_pkg::field_value_t acc_reg;
    gifd_pkg::field_value_t acc_cur;
    gifd_pkg::field_value_t sext_val;
    gifd_pkg::field_value_t fin_val;
    gifd_pkg::quality_t     fin_q;
    logic [5:0]             status;

    // Output register
    logic                   o_vld_reg;
    gifd_pkg::field_id_t    o_id_reg;
    gifd_pkg::field_value_t o_val_reg;
    gifd_pkg::quality_t     o_q_reg;
    logic                   o_last_reg;
    logic                   out_free;

    // ---------------------------------------------------------------------
    // Input side: frame position, store write and interlock against the emitter
    // ---------------------------------------------------------------------
    always_comb
    begin
        frame_end = {1'b0, len_reg} + POS_WIDTH'(gifd_pkg::STORE_FIRST);
        wr_off    = pos_reg - POS_WIDTH'(gifd_pkg::STORE_FIRST);
        in_body   = pos_reg >= POS_WIDTH'(gifd_pkg::STORE_FIRST);
        at_end    = in_body && (pos_reg == frame_end);
        past_end  = in_body && (pos_reg > frame_end);
        in_store  = in_body && (wr_off < POS_WIDTH'(gifd_pkg::STORE_DEPTH));

        // Hold the byte while the store entry it overwrites is still unread,
        // or while a closing byte would restart an emitter that is busy.
        blocked = busy_reg && in_body && !past_end &&
                  (at_end || (in_store && (wr_off[IDX_WIDTH_C-1:0] >= rd_idx_reg)));

        accept     = byte_in.valid && !blocked;
        wr_en      = accept && in_store && !past_end;
        emit_start = accept && at_end;

        pos_next = pos_reg;
        len_next = len_reg;
        if (accept)
        begin
            if (pos_reg == POS_WIDTH'(0))
            begin
                pos_next = (byte_in.data_byte == gifd_pkg::SYNC_FIRST) ? POS_WIDTH'(1)
                                                                       : POS_WIDTH'(0);
            end
            else if (pos_reg == POS_WIDTH'(1))
            begin
                pos_next = (byte_in.data_byte == gifd_pkg::SYNC_SECOND) ? POS_WIDTH'(2)
                                                                        : POS_WIDTH'(0);
            end
            else if (pos_reg == POS_WIDTH'(2))
            begin
                len_next = byte_in.data_byte;
                pos_next = POS_WIDTH'(3);
            end
            else if (past_end || at_end)
            begin
                pos_next = POS_WIDTH'(0);
            end
            else
            begin
                pos_next = pos_reg + POS_WIDTH'(1);
            end
        end
    end

    assign byte_in.ready = !blocked;

    // ---------------------------------------------------------------------
    // Emitter: issue one store read a cycle unless the data stage is held, walking fields in order
    // ---------------------------------------------------------------------
    assign out_free = !o_vld_reg || field_out.ready;
    assign d_take   = d_vld_reg && (!d_last_reg || out_free);
    assign rd_en    = busy_reg && (!d_vld_reg || d_take);
    assign f_lastb  = (f_bpos_reg == gifd_pkg::field_len(f_id_reg));

    // Store: write from the input side, registered read for the emitter
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_off[IDX_WIDTH_C-1:0]] <= byte_in.data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    // Field assembly: the first byte of a field starts from zero
    always_comb
    begin
        d_byte  = d_bv_reg ? rd_data_reg : 8'h00;
        acc_cur = ((d_bpos_reg == 3'd0) ? '0 : acc_reg) |
                  (gifd_pkg::field_value_t'(d_byte) << {d_bpos_reg, 3'b000});

        sext_val = {{48{acc_cur[15]}}, acc_cur[15:0]};
        status   = acc_cur[5:0] & gifd_pkg::STATUS_MASK[5:0];
        fin_q    = gifd_pkg::QUAL_BAD;

        case (d_id_reg) inside
            [gifd_pkg::ID_ACCEL_X:gifd_pkg::ID_RATE_Z]:
            begin
                // Negate the yaw rate after sign extension
                fin_val = (d_id_reg == gifd_pkg::ID_RATE_Z) ? ('0 - sext_val) : sext_val;
            end
            gifd_pkg::ID_STATUS:
            begin
                fin_val = gifd_pkg::field_value_t'(status);
                if (status == 6'd1)
                begin
                    fin_q = gifd_pkg::QUAL_CONVERGING;
                end
                else if (status == 6'd2)
                begin
                    fin_q = gifd_pkg::QUAL_GOOD;
                end
            end
            default:
            begin
                fin_val = acc_cur;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            vld_reg    <= '0;
            busy_reg   <= 1'b0;
            rd_idx_reg <= '0;
            f_id_reg   <= '0;
            f_bpos_reg <= '0;
            d_vld_reg  <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;

            if (wr_en)
            begin
                vld_reg[wr_off[IDX_WIDTH_C-1:0]] <= 1'b1;
            end

            if (emit_start)
            begin
                busy_reg   <= 1'b1;
                rd_idx_reg <= '0;
                f_id_reg   <= '0;
                f_bpos_reg <= '0;
            end
            else if (rd_en)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                if (rd_idx_reg == IDX_WIDTH_C'(LAST_IDX))
                begin
                    busy_reg <= 1'b0;
                end
                if (f_lastb)
                begin
                    f_bpos_reg <= '0;
                    f_id_reg   <= f_id_reg + 1'b1;
                end
                else
                begin
                    f_bpos_reg <= f_bpos_reg + 1'b1;
                end
            end

            if (rd_en)
            begin
                d_vld_reg <= 1'b1;
            end
            else if (d_take)
            begin
                d_vld_reg <= 1'b0;
            end

            if (d_take && d_last_reg)
            begin
                o_vld_reg <= 1'b1;
            end
            else if (field_out.ready)
            begin
                o_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            d_id_reg   <= f_id_reg;
            d_bpos_reg <= f_bpos_reg;
            d_last_reg <= f_lastb;
            d_bv_reg   <= vld_reg[rd_idx_reg];
        end
        if (d_take)
        begin
            acc_reg <= acc_cur;
        end
        if (d_take && d_last_reg)
        begin
            o_id_reg   <= d_id_reg;
            o_val_reg  <= fin_val;
            o_q_reg    <= fin_q;
            o_last_reg <= (d_id_reg == gifd_pkg::ID_STATUS);
        end
    end

    assign field_out.valid       = o_vld_reg;
    assign field_out.field_id    = o_id_reg;
    assign field_out.field_value = o_val_reg;
    assign field_out.quality     = o_q_reg;
    assign field_out.last_field  = o_last_reg;

endmodule

@@ rtl/gifd_checker.sv @@
// Port-level checker for the GNSS/IMU frame deframer, bound to the top level.
// Depends on gifd_pkg and gnss_imu_frame_deframer_core.
module gifd_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input gifd_pkg::field_id_t    field_id,
    input gifd_pkg::field_value_t field_value,
    input gifd_pkg::quality_t     quality,
    input logic                   last_field
);

    // A stalled request holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(field_id) && $stable(field_value)
                                    && $stable(quality) && $stable(last_field))
        else $error("field request changed while stalled");

    // The run ends exactly at the status field
    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_field == (field_id == gifd_pkg::ID_STATUS)))
        else $error("last_field does not match the status field");

    // Quality is only set on the status field
    a_quality_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (quality != gifd_pkg::QUAL_BAD) |-> field_id == gifd_pkg::ID_STATUS)
        else $error("quality set on a non-status field");

    // Status carries six bits and a matching quality code
    a_status_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_id == gifd_pkg::ID_STATUS |->
            field_value[63:6] == '0 &&
            ((quality == gifd_pkg::QUAL_CONVERGING) == (field_value == 64'd1)) &&
            ((quality == gifd_pkg::QUAL_GOOD) == (field_value == 64'd2)))
        else $error("status field value and quality disagree");

endmodule

bind gnss_imu_frame_deframer_core gifd_checker u_gifd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (field_out.valid),
    .out_ready   (field_out.ready),
    .field_id    (field_out.field_id),
    .field_value (field_out.field_value),
    .quality     (field_out.quality),
    .last_field  (field_out.last_field)
);
